@@ hdl/atce_pkg.sv @@
// Package for the ANSI text console engine: screen geometry, byte codes,
// parser and controller state types, and the controller/datapath link structs.
// Used by atce_ctrl, atce_dp and ansi_text_console_engine; depends on nothing.
package atce_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;
    localparam int MAX_PARAMS    = 8;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int POS_W  = 11;
    localparam int PIDX_W = 3;
    localparam int PCNT_W = 4;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_W      = 49;
    localparam int OUT_DATA_W = 56;

    localparam logic [7:0] COLOR_RESET = 8'h0F;
    localparam logic [3:0] FG_DEFAULT  = 4'd7;
    localparam logic [7:0] TAB_STEP    = 8'd4;

    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_SGR    = 8'h6D;
    localparam logic [7:0] CH_CLEAR  = 8'h4A;
    localparam logic [7:0] CH_HOME   = 8'h48;
    localparam logic [7:0] CH_UP     = 8'h41;
    localparam logic [7:0] CH_DOWN   = 8'h42;
    localparam logic [7:0] CH_RIGHT  = 8'h43;
    localparam logic [7:0] CH_LEFT   = 8'h44;

    localparam logic [7:0] SGR_RESET    = 8'd0;
    localparam logic [7:0] SGR_BOLD     = 8'd1;
    localparam logic [7:0] SGR_NOBOLD   = 8'd22;
    localparam logic [7:0] SGR_FG_LO    = 8'd30;
    localparam logic [7:0] SGR_FG_HI    = 8'd37;
    localparam logic [7:0] SGR_FG_DEF   = 8'd39;
    localparam logic [7:0] SGR_BG_LO    = 8'd40;
    localparam logic [7:0] SGR_BG_HI    = 8'd47;
    localparam logic [7:0] SGR_BG_DEF   = 8'd49;
    localparam logic [7:0] SGR_FGB_LO   = 8'd90;
    localparam logic [7:0] SGR_FGB_HI   = 8'd97;
    localparam logic [7:0] SGR_BGB_LO   = 8'd100;
    localparam logic [7:0] SGR_BGB_HI   = 8'd107;
    localparam logic [7:0] SGR_CLR_ALL  = 8'd2;

    localparam logic [2:0] COLOR_MAP [8] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

    typedef enum logic [3:0] {
        PS_NORMAL  = 4'b0001,
        PS_ESCAPE  = 4'b0010,
        PS_BRACKET = 4'b0100,
        PS_PARAM   = 4'b1000
    } t_parse_state;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_SGR  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_ctrl_state;

    typedef struct packed {
        logic capture;
        logic exec;
        logic sgr_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic sgr_start;
        logic sgr_last;
        logic out_free;
    } t_status;

endpackage

@@ hdl/atce_ctrl.sv @@
// Sequencing controller of the console engine: capture, execute, SGR walk, output load.
// Depends on atce_pkg; drives atce_dp through t_cmd and reads t_status back.
module atce_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  atce_pkg::t_status  i_status,
    output atce_pkg::t_cmd     o_cmd
);

    atce_pkg::t_ctrl_state r_state;
    atce_pkg::t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= atce_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            atce_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = atce_pkg::ST_EXEC;
                end
            end
            atce_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_status.sgr_start ? atce_pkg::ST_SGR : atce_pkg::ST_FIN;
            end
            atce_pkg::ST_SGR: begin
                o_cmd.sgr_step = 1'b1;
                if (i_status.sgr_last) begin
                    n_state = atce_pkg::ST_FIN;
                end
            end
            atce_pkg::ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = atce_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = atce_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ hdl/atce_dp.sv @@
// Datapath of the console engine: parser, parameters, cursor, attribute and result register.
// Depends on atce_pkg; controlled by atce_ctrl through t_cmd.
module atce_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [7:0]                         i_cfg_wdata,
    input  logic                               i_op,
    input  logic [atce_pkg::IN_DATA_W-1:0]     i_data,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [atce_pkg::OUT_DATA_W-1:0]    o_out_data,
    input  atce_pkg::t_cmd                     i_cmd,
    output atce_pkg::t_status                  o_status
);

    typedef struct packed {
        logic [7:0] color;
        logic       bold;
    } t_attr;

    function automatic t_attr sgr_apply(input logic [7:0] code, input logic [7:0] color,
                                        input logic bold, input logic [7:0] defc);
        logic [3:0] fg;
        logic [3:0] bg;
        t_attr      res;
        fg        = color[3:0];
        bg        = color[7:4];
        res.color = color;
        res.bold  = bold;
        if (code == atce_pkg::SGR_RESET) begin
            res.color = defc;
            res.bold  = 1'b0;
        end else if (code == atce_pkg::SGR_BOLD) begin
            res.bold = 1'b1;
            if (!fg[3]) res.color = {bg, 1'b1, fg[2:0]};
        end else if (code == atce_pkg::SGR_NOBOLD) begin
            res.bold = 1'b0;
            if (fg[3]) res.color = {bg, 1'b0, fg[2:0]};
        end else if (code >= atce_pkg::SGR_FG_LO && code <= atce_pkg::SGR_FG_HI) begin
            res.color = {bg, bold, atce_pkg::COLOR_MAP[3'(code - atce_pkg::SGR_FG_LO)]};
        end else if (code == atce_pkg::SGR_FG_DEF) begin
            res.color = {bg, atce_pkg::FG_DEFAULT};
        end else if (code >= atce_pkg::SGR_BG_LO && code <= atce_pkg::SGR_BG_HI) begin
            res.color = {1'b0, atce_pkg::COLOR_MAP[3'(code - atce_pkg::SGR_BG_LO)], fg};
        end else if (code == atce_pkg::SGR_BG_DEF) begin
            res.color = {4'd0, fg};
        end else if (code >= atce_pkg::SGR_FGB_LO && code <= atce_pkg::SGR_FGB_HI) begin
            res.color = {bg, 1'b1, atce_pkg::COLOR_MAP[3'(code - atce_pkg::SGR_FGB_LO)]};
        end else if (code >= atce_pkg::SGR_BGB_LO && code <= atce_pkg::SGR_BGB_HI) begin
            res.color = {1'b1, atce_pkg::COLOR_MAP[3'(code - atce_pkg::SGR_BGB_LO)], fg};
        end
        return res;
    endfunction

    logic [7:0]                   r_default;
    logic [7:0]                   n_default;
    atce_pkg::t_parse_state       r_ps;
    atce_pkg::t_parse_state       n_ps;
    logic [7:0]                   r_vals [atce_pkg::MAX_PARAMS];
    logic [7:0]                   n_vals [atce_pkg::MAX_PARAMS];
    logic [atce_pkg::PCNT_W-1:0]  r_cnt;
    logic [atce_pkg::PCNT_W-1:0]  n_cnt;
    logic [atce_pkg::PIDX_W-1:0]  r_sgr_idx;
    logic [atce_pkg::PIDX_W-1:0]  n_sgr_idx;
    logic [atce_pkg::ROW_W-1:0]   r_row;
    logic [atce_pkg::ROW_W-1:0]   n_row;
    logic [atce_pkg::COL_W-1:0]   r_col;
    logic [atce_pkg::COL_W-1:0]   n_col;
    logic [7:0]                   r_color;
    logic [7:0]                   n_color;
    logic                         r_bold;
    logic                         n_bold;
    logic                         r_op;
    logic                         n_op;
    logic [7:0]                   r_char;
    logic [7:0]                   n_char;
    logic [3:0]                   r_fg;
    logic [3:0]                   n_fg;
    logic [3:0]                   r_bg;
    logic [3:0]                   n_bg;
    logic                         r_wr;
    logic                         n_wr;
    logic [atce_pkg::POS_W-1:0]   r_addr;
    logic [atce_pkg::POS_W-1:0]   n_addr;
    logic [15:0]                  r_entry;
    logic [15:0]                  n_entry;
    logic                         r_scroll;
    logic                         n_scroll;
    logic                         r_clr;
    logic                         n_clr;
    logic                         r_out_valid;
    logic                         n_out_valid;
    logic [atce_pkg::OUT_DATA_W-1:0] r_out_data;
    logic [atce_pkg::OUT_DATA_W-1:0] n_out_data;

    logic [7:0]                   p_first;
    logic [7:0]                   move_n;
    logic [atce_pkg::PIDX_W-1:0]  dig_idx;
    logic [7:0]                   dig_base;
    logic [11:0]                  dig_val;
    logic [atce_pkg::PCNT_W-1:0]  cnt_min1;
    logic [8:0]                   row_sum;
    logic [8:0]                   col_sum;
    logic [7:0]                   tab_col;
    logic [atce_pkg::ROW_W-1:0]   nl_row;
    logic                         nl_scroll;
    logic                         wrap;
    logic [atce_pkg::ROW_W-1:0]   wr_row;
    logic [atce_pkg::COL_W-1:0]   wr_col;
    logic                         is_digit;
    logic                         ordinary;
    logic                         sgr_last;
    logic [atce_pkg::POS_W-1:0]   cur_pos;
    t_attr                        sgr_res;

    always_comb begin
        p_first   = (r_cnt != '0) ? r_vals[0] : 8'd0;
        move_n    = (p_first == 8'd0) ? 8'd1 : p_first;
        dig_idx   = (r_cnt == '0) ? '0 : atce_pkg::PIDX_W'(r_cnt - 1'b1);
        dig_base  = (r_cnt == '0) ? 8'd0 : r_vals[dig_idx];
        dig_val   = ({4'd0, dig_base} << 3) + ({4'd0, dig_base} << 1)
                  + {4'd0, r_char - atce_pkg::CH_ZERO};
        cnt_min1  = (r_cnt == '0) ? atce_pkg::PCNT_W'(1) : r_cnt;
        row_sum   = {4'd0, r_row} + {1'b0, move_n};
        col_sum   = {2'd0, r_col} + {1'b0, move_n};
        tab_col   = ({1'b0, r_col} + atce_pkg::TAB_STEP) & 8'hFC;
        nl_scroll = ({3'd0, r_row} + 8'd1) >= 8'(atce_pkg::SCREEN_HEIGHT);
        nl_row    = nl_scroll ? atce_pkg::ROW_W'(atce_pkg::SCREEN_HEIGHT - 1) : r_row + 1'b1;
        wrap      = {1'b0, r_col} >= 8'(atce_pkg::SCREEN_WIDTH);
        wr_row    = wrap ? nl_row : r_row;
        wr_col    = wrap ? '0 : r_col;
        is_digit  = (r_char >= atce_pkg::CH_ZERO) && (r_char <= atce_pkg::CH_NINE);
        sgr_last  = (atce_pkg::PCNT_W'(r_sgr_idx) + 1'b1) == r_cnt;
        sgr_res   = sgr_apply(r_vals[r_sgr_idx], r_color, r_bold, r_default);
        cur_pos   = atce_pkg::POS_W'(r_row * atce_pkg::SCREEN_WIDTH) + atce_pkg::POS_W'(r_col);
    end

    always_comb begin
        n_default   = i_cfg_we ? i_cfg_wdata : r_default;
        n_ps        = r_ps;
        n_vals      = r_vals;
        n_cnt       = r_cnt;
        n_sgr_idx   = r_sgr_idx;
        n_row       = r_row;
        n_col       = r_col;
        n_color     = r_color;
        n_bold      = r_bold;
        n_op        = r_op;
        n_char      = r_char;
        n_fg        = r_fg;
        n_bg        = r_bg;
        n_wr        = r_wr;
        n_addr      = r_addr;
        n_entry     = r_entry;
        n_scroll    = r_scroll;
        n_clr       = r_clr;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        ordinary    = 1'b0;
        o_status    = '0;

        if (i_cmd.capture) begin
            n_op   = i_op;
            n_char = i_data[7:0];
            n_fg   = i_data[11:8];
            n_bg   = i_data[15:12];
        end

        if (i_cmd.exec) begin
            n_wr     = 1'b0;
            n_addr   = '0;
            n_entry  = '0;
            n_scroll = 1'b0;
            n_clr    = 1'b0;
            ordinary = 1'b1;
            if (r_op) begin
                n_color  = {r_bg, r_fg};
                ordinary = 1'b0;
            end else begin
                case (r_ps)
                    atce_pkg::PS_NORMAL: begin
                        if (r_char == atce_pkg::CH_ESC) begin
                            n_ps     = atce_pkg::PS_ESCAPE;
                            ordinary = 1'b0;
                        end
                    end
                    atce_pkg::PS_ESCAPE: begin
                        if (r_char == atce_pkg::CH_LBRACK) begin
                            n_ps     = atce_pkg::PS_BRACKET;
                            n_cnt    = '0;
                            ordinary = 1'b0;
                        end else begin
                            n_ps = atce_pkg::PS_NORMAL;
                        end
                    end
                    default: begin
                        ordinary = 1'b0;
                        if (is_digit) begin
                            n_vals[dig_idx] = (dig_val > 12'd255) ? 8'd255 : dig_val[7:0];
                            n_cnt           = cnt_min1;
                            n_ps            = atce_pkg::PS_PARAM;
                        end else if (r_char == atce_pkg::CH_SEMI) begin
                            if (r_cnt == '0) n_vals[0] = 8'd0;
                            n_cnt = cnt_min1;
                            if (cnt_min1 < atce_pkg::PCNT_W'(atce_pkg::MAX_PARAMS)) begin
                                n_vals[cnt_min1[atce_pkg::PIDX_W-1:0]] = 8'd0;
                                n_cnt = cnt_min1 + 1'b1;
                            end
                        end else begin
                            n_ps  = atce_pkg::PS_NORMAL;
                            n_cnt = '0;
                            case (r_char)
                                atce_pkg::CH_SGR: begin
                                    o_status.sgr_start = 1'b1;
                                    if (r_cnt == '0) n_vals[0] = 8'd0;
                                    n_cnt     = cnt_min1;
                                    n_sgr_idx = '0;
                                end
                                atce_pkg::CH_CLEAR: begin
                                    if (p_first == 8'd0 || p_first == atce_pkg::SGR_CLR_ALL) begin
                                        n_clr = 1'b1;
                                        n_row = '0;
                                        n_col = '0;
                                    end
                                end
                                atce_pkg::CH_HOME: begin
                                    if (p_first == 8'd0) begin
                                        n_row = '0;
                                        n_col = '0;
                                    end
                                end
                                atce_pkg::CH_UP: begin
                                    n_row = ({3'd0, r_row} >= move_n)
                                          ? atce_pkg::ROW_W'({3'd0, r_row} - move_n) : '0;
                                end
                                atce_pkg::CH_DOWN: begin
                                    n_row = (row_sum < 9'(atce_pkg::SCREEN_HEIGHT))
                                          ? row_sum[atce_pkg::ROW_W-1:0]
                                          : atce_pkg::ROW_W'(atce_pkg::SCREEN_HEIGHT - 1);
                                end
                                atce_pkg::CH_RIGHT: begin
                                    n_col = (col_sum < 9'(atce_pkg::SCREEN_WIDTH))
                                          ? col_sum[atce_pkg::COL_W-1:0]
                                          : atce_pkg::COL_W'(atce_pkg::SCREEN_WIDTH - 1);
                                end
                                atce_pkg::CH_LEFT: begin
                                    n_col = ({1'b0, r_col} >= move_n)
                                          ? atce_pkg::COL_W'({1'b0, r_col} - move_n) : '0;
                                end
                                default: begin
                                    ordinary = 1'b1;
                                end
                            endcase
                        end
                    end
                endcase
            end

            if (ordinary) begin
                case (r_char)
                    atce_pkg::CH_NL: begin
                        n_col    = '0;
                        n_row    = nl_row;
                        n_scroll = nl_scroll;
                    end
                    atce_pkg::CH_CR: begin
                        n_col = '0;
                    end
                    atce_pkg::CH_TAB: begin
                        if (tab_col >= 8'(atce_pkg::SCREEN_WIDTH)) begin
                            n_col    = '0;
                            n_row    = nl_row;
                            n_scroll = nl_scroll;
                        end else begin
                            n_col = tab_col[atce_pkg::COL_W-1:0];
                        end
                    end
                    atce_pkg::CH_BS: begin
                        if (r_col != '0) n_col = r_col - 1'b1;
                    end
                    default: begin
                        n_scroll = wrap & nl_scroll;
                        n_row    = wr_row;
                        n_wr     = 1'b1;
                        n_addr   = atce_pkg::POS_W'(wr_row * atce_pkg::SCREEN_WIDTH)
                                 + atce_pkg::POS_W'(wr_col);
                        n_entry  = {r_color, r_char};
                        n_col    = wr_col + 1'b1;
                    end
                endcase
            end
        end

        if (i_cmd.sgr_step) begin
            n_color = sgr_res.color;
            n_bold  = sgr_res.bold;
            if (sgr_last) begin
                n_sgr_idx = '0;
                n_cnt     = '0;
            end else begin
                n_sgr_idx = r_sgr_idx + 1'b1;
            end
        end

        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
            n_out_data  = {(atce_pkg::OUT_DATA_W - atce_pkg::OUT_W)'(0), r_color, cur_pos,
                           r_clr, r_scroll, r_entry, r_addr, r_wr};
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        o_status.sgr_last = sgr_last;
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default   <= atce_pkg::COLOR_RESET;
            r_ps        <= atce_pkg::PS_NORMAL;
            r_vals      <= '{default: 8'd0};
            r_cnt       <= '0;
            r_sgr_idx   <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_color     <= atce_pkg::COLOR_RESET;
            r_bold      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_default   <= n_default;
            r_ps        <= n_ps;
            r_vals      <= n_vals;
            r_cnt       <= n_cnt;
            r_sgr_idx   <= n_sgr_idx;
            r_row       <= n_row;
            r_col       <= n_col;
            r_color     <= n_color;
            r_bold      <= n_bold;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_char     <= n_char;
        r_fg       <= n_fg;
        r_bg       <= n_bg;
        r_wr       <= n_wr;
        r_addr     <= n_addr;
        r_entry    <= n_entry;
        r_scroll   <= n_scroll;
        r_clr      <= n_clr;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ hdl/ansi_text_console_engine.sv @@
// Top level of the ANSI text console engine with CSI/SGR subset.
// Depends on atce_pkg, atce_ctrl and atce_dp.
// Each item is captured, executed, for CSI m walked one stored SGR parameter (1 to 8) at a
// time, and its result loaded; a new item is accepted only once the previous one is done.
// A result still waiting on the output holds the next item before its load until taken.
// Reset (synchronous, active low): cursor home, attribute and default 0x0F, parser idle.
module ansi_text_console_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [7:0]                         i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] char_code, [11:8] fg_color, [15:12] bg_color
    input  logic [atce_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [0] operation
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] cell_write, [11:1] cell_address, [27:12] cell_entry, [28] scroll_up,
    // [29] clear_screen, [40:30] cursor_position, [48:41] text_color, [55:49] zero
    output logic [atce_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    atce_pkg::t_cmd    cmd;
    atce_pkg::t_status status;

    atce_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    atce_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_op        (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule
